// File: rtl/qle_pkg.sv
// ----------------------------------------------------------------------------
// qle_pkg: shared types and constants for the tabular Q-learning engine
// Request and response payloads, mode and register codes, controller states,
// and the saturating arithmetic helpers used by the update datapath.
// ----------------------------------------------------------------------------
package qle_pkg;

  // Field widths
  localparam int Q_W      = 32;  // Q16.16 values and rewards
  localparam int FRAC_W   = 16;  // fraction bits of Q16.16
  localparam int COEF_W   = 16;  // alpha and gamma, unsigned Q0.16
  localparam int MODE_W   = 2;
  localparam int STATE_W  = 9;
  localparam int ACTION_W = 2;
  localparam int SUM_W    = Q_W + 2;  // headroom for the sums before saturation

  // Default table shape
  localparam int STATE_COUNT_DEF  = 512;
  localparam int ACTION_COUNT_DEF = 4;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [COEF_W-1:0] ALPHA_RST = 16'd6554;
  localparam logic [COEF_W-1:0] GAMMA_RST = 16'd58982;

  typedef enum logic [MODE_W-1:0] {
    MODE_UPDATE   = 2'd0,
    MODE_TERMINAL = 2'd1,
    MODE_GREEDY   = 2'd2,
    MODE_READ     = 2'd3
  } mode_t;

  // Register index, taken from paddr[2]
  typedef enum logic {
    CFG_ALPHA = 1'b0,
    CFG_GAMMA = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,  // zero the table after reset
    S_IDLE,   // wait for a request
    S_NS,     // next-state row arrives, take its maximum
    S_ROW,    // own row arrives
    S_T1,     // target = reward + gamma * max
    S_DIFF,   // target - old
    S_MULA,   // alpha * diff
    S_WB      // write back the new entry
  } state_t;

  typedef struct packed {
    mode_t                       mode;
    logic [STATE_W-1:0]          state_index;
    logic [ACTION_W-1:0]         action_index;
    logic signed [Q_W-1:0]       reward;
    logic [STATE_W-1:0]          next_state_index;
  } in_req_t;

  typedef struct packed {
    logic [ACTION_W-1:0]         best_action;
    logic signed [Q_W-1:0]       q_value;
  } out_rsp_t;

  // Sign-extend a Q16.16 value to the sum width
  function automatic logic signed [SUM_W-1:0] widen(input logic [Q_W-1:0] x);
    return {{(SUM_W-Q_W){x[Q_W-1]}}, x};
  endfunction

  // Clamp a sum to the signed 32-bit range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-Q_W:0] top;
    top = x[SUM_W-1:Q_W-1];
    if (top == '0 || top == '1) begin
      return x[Q_W-1:0];
    end else if (x[SUM_W-1]) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/tabular_q_learning_engine.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_engine: Q table with TD update, greedy query and read
// One row-wide synchronous memory holds the table; a small controller reads
// rows, runs the fixed-point update and writes the row back.
// ----------------------------------------------------------------------------
// The Q table is one memory of STATE_COUNT rows, each row holding all
// ACTION_COUNT entries, with one read and one write per cycle. After reset the
// block zeroes the table, one row per cycle, and holds in_ready low meanwhile;
// configuration writes are taken at any time. One request is worked on at a
// time. An update (mode 0) reads the next-state row and then its own row
// through the same port and then goes through two dependent multiplies, a
// subtract and the write-back; a terminal update reads only its own row, a
// greedy query or entry read only reads its row, and a request whose state or
// action is out of range gets a zero result with no table access. A finished
// result waits in the output register, so the next request can start before
// it is taken. The row maximum and greedy action come from a compare tree over
// one row.
module tabular_q_learning_engine #(
  parameter int STATE_COUNT  = qle_pkg::STATE_COUNT_DEF,
  parameter int ACTION_COUNT = qle_pkg::ACTION_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qle_pkg::in_req_t              in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output qle_pkg::out_rsp_t             out_data,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [qle_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [qle_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [qle_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);

  localparam int AW    = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
  localparam int AIW   = $clog2(ACTION_COUNT);
  localparam int LEAF  = 1 << AIW;
  localparam int Q_W   = qle_pkg::Q_W;
  localparam int SUM_W = qle_pkg::SUM_W;
  localparam int PROD_W = qle_pkg::COEF_W + Q_W + 1;

  typedef logic [ACTION_COUNT-1:0][Q_W-1:0] row_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [qle_pkg::COEF_W-1:0] alpha_r;
  logic [qle_pkg::COEF_W-1:0] gamma_r;
  logic                       cfg_wr;
  qle_pkg::cfg_reg_t          cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = qle_pkg::cfg_reg_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= qle_pkg::ALPHA_RST;
      gamma_r <= qle_pkg::GAMMA_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        qle_pkg::CFG_ALPHA: alpha_r <= cfg_pwdata[qle_pkg::COEF_W-1:0];
        qle_pkg::CFG_GAMMA: gamma_r <= cfg_pwdata[qle_pkg::COEF_W-1:0];
        default:            alpha_r <= alpha_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      qle_pkg::CFG_ALPHA: cfg_prdata = {{(qle_pkg::CFG_DATA_W-qle_pkg::COEF_W){1'b0}}, alpha_r};
      qle_pkg::CFG_GAMMA: cfg_prdata = {{(qle_pkg::CFG_DATA_W-qle_pkg::COEF_W){1'b0}}, gamma_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  qle_pkg::state_t        state_r, state_nxt;
  logic [AW-1:0]          clr_cnt_r, clr_cnt_nxt;

  qle_pkg::in_req_t       req_r;
  logic                   s_ok_r, a_ok_r, ns_ok_r;
  logic                   in_fire;
  logic                   s_ok_in, a_ok_in, ns_ok_in, req_ok_in;

  row_t                   mem [STATE_COUNT];
  row_t                   mem_rdata_r;
  logic                   mem_re, mem_we;
  logic [AW-1:0]          mem_raddr, mem_waddr;
  row_t                   mem_wdata;

  row_t                   row_r;
  logic [AIW-1:0]         a_sel;
  logic signed [Q_W-1:0]  old_r, mx_r, t1_r, d_r;
  logic signed [PROD_W-1:0] prod_g_r, prod_a_r;
  logic signed [PROD_W-1:0] sh_g, sh_a;
  logic signed [Q_W-1:0]  t1_val, d_val, nv_val;

  logic signed [Q_W-1:0]  node_val [1:2*LEAF-1];
  logic [AIW-1:0]         node_idx [1:2*LEAF-1];
  logic                   node_vld [1:2*LEAF-1];
  logic signed [Q_W-1:0]  tree_val;
  logic [AIW-1:0]         tree_idx;

  logic [qle_pkg::ACTION_W-1:0] res_best_r;
  logic signed [Q_W-1:0]  res_q_r;
  logic                   out_valid_r;
  qle_pkg::out_rsp_t      out_data_r;
  logic                   out_load;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  assign in_fire  = in_valid && in_ready;
  assign s_ok_in  = 32'(in_data.state_index) < STATE_COUNT;
  assign a_ok_in  = 32'(in_data.action_index) < ACTION_COUNT;
  assign ns_ok_in = 32'(in_data.next_state_index) < STATE_COUNT;
  // greedy query needs only the row; the others need a valid column too
  assign req_ok_in = s_ok_in && (a_ok_in || in_data.mode == qle_pkg::MODE_GREEDY);
  assign a_sel    = AIW'(req_r.action_index);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r   <= in_data;
      s_ok_r  <= s_ok_in;
      a_ok_r  <= a_ok_in;
      ns_ok_r <= ns_ok_in;
    end
  end

  // --------------------------------------------------------------------------
  // Table memory: one row per state, read data registered
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Row compare tree: maximum, lowest index wins a tie
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < LEAF; i++) begin
      if (i < ACTION_COUNT) begin
        node_val[LEAF+i] = mem_rdata_r[i];
        node_vld[LEAF+i] = 1'b1;
      end else begin
        node_val[LEAF+i] = '0;
        node_vld[LEAF+i] = 1'b0;
      end
      node_idx[LEAF+i] = AIW'(i);
    end
    for (int n = LEAF - 1; n >= 1; n--) begin
      if (node_vld[2*n+1] && (!node_vld[2*n] || node_val[2*n+1] > node_val[2*n])) begin
        node_val[n] = node_val[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end else begin
        node_val[n] = node_val[2*n];
        node_idx[n] = node_idx[2*n];
      end
      node_vld[n] = node_vld[2*n] || node_vld[2*n+1];
    end
    tree_val = node_val[1];
    tree_idx = node_idx[1];
  end

  // --------------------------------------------------------------------------
  // Update arithmetic, one step per state
  // --------------------------------------------------------------------------
  assign sh_g   = prod_g_r >>> qle_pkg::FRAC_W;
  assign sh_a   = prod_a_r >>> qle_pkg::FRAC_W;
  assign t1_val = qle_pkg::sat_q(qle_pkg::widen(req_r.reward) + sh_g[SUM_W-1:0]);
  assign d_val  = qle_pkg::sat_q(qle_pkg::widen(t1_r) - qle_pkg::widen(old_r));
  assign nv_val = qle_pkg::sat_q(qle_pkg::widen(old_r) + sh_a[SUM_W-1:0]);

  always_ff @(posedge clk) begin
    unique case (state_r)
      qle_pkg::S_NS: begin
        // next-state row max, zero when that row does not exist
        mx_r <= ns_ok_r ? tree_val : '0;
      end
      qle_pkg::S_ROW: begin
        row_r    <= mem_rdata_r;
        old_r    <= mem_rdata_r[a_sel];
        prod_g_r <= $signed({1'b0, gamma_r}) * mx_r;
      end
      qle_pkg::S_T1: begin
        t1_r <= (req_r.mode == qle_pkg::MODE_UPDATE) ? t1_val : req_r.reward;
      end
      qle_pkg::S_DIFF: begin
        d_r <= d_val;
      end
      qle_pkg::S_MULA: begin
        prod_a_r <= $signed({1'b0, alpha_r}) * d_r;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register, loaded before the output stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire && !req_ok_in) begin
      res_best_r <= '0;
      res_q_r    <= '0;
    end else if (state_r == qle_pkg::S_ROW && req_r.mode == qle_pkg::MODE_GREEDY) begin
      res_best_r <= qle_pkg::ACTION_W'(tree_idx);
      res_q_r    <= tree_val;
    end else if (state_r == qle_pkg::S_ROW && req_r.mode == qle_pkg::MODE_READ) begin
      res_best_r <= '0;
      res_q_r    <= mem_rdata_r[a_sel];
    end else if (state_r == qle_pkg::S_WB) begin
      res_best_r <= '0;
      res_q_r    <= nv_val;
    end
  end

  // --------------------------------------------------------------------------
  // Controller: state register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= qle_pkg::S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // pending flag: result sits in res_* waiting for the output register
  logic res_pend_r, res_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_pend_r <= 1'b0;
    end else begin
      res_pend_r <= res_pend_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Controller: next state and memory controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    in_ready     = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = AW'(in_data.state_index);
    mem_we       = 1'b0;
    mem_waddr    = AW'(req_r.state_index);
    mem_wdata    = row_r;
    out_load     = res_pend_r && (!out_valid_r || out_ready);
    res_pend_nxt = res_pend_r && !out_load;

    unique case (state_r)
      qle_pkg::S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(STATE_COUNT - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = qle_pkg::S_IDLE;
        end
      end
      qle_pkg::S_IDLE: begin
        // a new request waits only for the previous result to leave res_*
        in_ready = !res_pend_r || out_load;
        if (in_fire) begin
          if (!req_ok_in) begin
            res_pend_nxt = 1'b1;
          end else if (in_data.mode == qle_pkg::MODE_UPDATE) begin
            mem_re    = ns_ok_in;
            mem_raddr = AW'(in_data.next_state_index);
            state_nxt = qle_pkg::S_NS;
          end else begin
            mem_re    = 1'b1;
            state_nxt = qle_pkg::S_ROW;
          end
        end
      end
      qle_pkg::S_NS: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(req_r.state_index);
        state_nxt = qle_pkg::S_ROW;
      end
      qle_pkg::S_ROW: begin
        if (req_r.mode == qle_pkg::MODE_GREEDY || req_r.mode == qle_pkg::MODE_READ) begin
          res_pend_nxt = 1'b1;
          state_nxt    = qle_pkg::S_IDLE;
        end else begin
          state_nxt = qle_pkg::S_T1;
        end
      end
      qle_pkg::S_T1:   state_nxt = qle_pkg::S_DIFF;
      qle_pkg::S_DIFF: state_nxt = qle_pkg::S_MULA;
      qle_pkg::S_MULA: state_nxt = qle_pkg::S_WB;
      qle_pkg::S_WB: begin
        mem_we           = 1'b1;
        mem_wdata[a_sel] = nv_val;
        res_pend_nxt     = 1'b1;
        state_nxt        = qle_pkg::S_IDLE;
      end
      default: state_nxt = qle_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.best_action <= res_best_r;
      out_data_r.q_value     <= res_q_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // one request in flight: an accepted in-range request blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && req_ok_in |=> !in_ready)
    else $error("request accepted while another is in progress");

  // write-back only for a row and column that exist
  a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == qle_pkg::S_WB |-> s_ok_r && a_ok_r)
    else $error("write-back for an out-of-range entry");

  // clearing ends only after the last row has been zeroed
  a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(state_r == qle_pkg::S_CLEAR) |-> $past(clr_cnt_r) == AW'(STATE_COUNT - 1))
    else $error("table clear ended early");

  // only a greedy query reports a nonzero action
  a_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && req_r.mode != qle_pkg::MODE_GREEDY |-> res_best_r == '0)
    else $error("nonzero best_action outside greedy query");

  // a pending result is never overwritten before it moves to the output
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_pend_r && !out_load |=> res_pend_r)
    else $error("pending result lost");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tabular Q-learning engine
// Drives requests with random gaps, writes alpha and gamma over the
// configuration port between phases, and checks every result against an
// in-bench model of the Q table and its fixed-point update.
// ----------------------------------------------------------------------------
module testbench;

  localparam int Q_W                = qle_pkg::Q_W;
  localparam int COEF_W             = qle_pkg::COEF_W;
  localparam int FRAC_W             = qle_pkg::FRAC_W;
  localparam int STATE_W            = qle_pkg::STATE_W;
  localparam int ACTION_W           = qle_pkg::ACTION_W;
  localparam int CFG_ADDR_W         = qle_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W         = qle_pkg::CFG_DATA_W;
  localparam int ROWS               = qle_pkg::STATE_COUNT_DEF;
  localparam int COLS               = qle_pkg::ACTION_COUNT_DEF;
  localparam int RESET_CYCLES       = 11;
  localparam int RESULT_HOLD_CYCLES = 200;   // long receiver hold-off
  localparam int SETTLE_CYCLES      = 12;    // longer than one update
  localparam int STALL_LIMIT        = 4000;  // covers the clear pass and hold-off
  localparam int PRINT_LIMIT        = 50;
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  qle_pkg::in_req_t      in_data;
  logic                  out_valid;
  logic                  out_ready;
  qle_pkg::out_rsp_t     out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tabular_q_learning_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Bench copy of the table and coefficients
  logic signed [Q_W-1:0] q_table [ROWS][COLS];
  logic [COEF_W-1:0]     alpha_coef;
  logic [COEF_W-1:0]     gamma_coef;
  qle_pkg::out_rsp_t     pending_results [$];

  int error_count  = 0;
  int idle_cycles  = 0;
  int in_idle_pct  = 25;
  int out_idle_pct = 15;
  bit hold_results = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic logic signed [Q_W-1:0] clamp_q(longint x);
    if (x > longint'(Q_MAX)) return Q_MAX;
    if (x < longint'(Q_MIN)) return Q_MIN;
    return x[Q_W-1:0];
  endfunction

  // Q0.16 coefficient times Q16.16 value, floored back to Q16.16
  function automatic longint scale_coef(logic [COEF_W-1:0] c, logic signed [Q_W-1:0] v);
    longint cl;
    longint vl;
    cl = c;
    vl = v;
    return (cl * vl) >>> FRAC_W;
  endfunction

  // Greedy column of a row; the lowest index wins a tie
  function automatic int best_col(int row);
    int best;
    best = 0;
    for (int a = 1; a < COLS; a++) begin
      if (q_table[row][a] > q_table[row][best]) best = a;
    end
    return best;
  endfunction

  function automatic qle_pkg::out_rsp_t predict_step(qle_pkg::in_req_t req);
    qle_pkg::out_rsp_t     rsp;
    int                    s;
    int                    a;
    int                    ns;
    int                    b;
    logic signed [Q_W-1:0] old_v;
    logic signed [Q_W-1:0] target;
    logic signed [Q_W-1:0] diff;
    logic signed [Q_W-1:0] peak;
    rsp = '0;
    s   = req.state_index;
    a   = req.action_index;
    ns  = req.next_state_index;
    if (s < ROWS) begin
      if (req.mode == qle_pkg::MODE_GREEDY) begin
        b = best_col(s);
        rsp.best_action = ACTION_W'(b);
        rsp.q_value     = q_table[s][b];
      end else if (a < COLS) begin
        old_v = q_table[s][a];
        if (req.mode == qle_pkg::MODE_READ) begin
          rsp.q_value = old_v;
        end else begin
          target = req.reward;
          if (req.mode == qle_pkg::MODE_UPDATE) begin
            peak   = (ns < ROWS) ? q_table[ns][best_col(ns)] : '0;
            target = clamp_q(longint'(req.reward) + scale_coef(gamma_coef, peak));
          end
          diff = clamp_q(longint'(target) - longint'(old_v));
          q_table[s][a] = clamp_q(longint'(old_v) + scale_coef(alpha_coef, diff));
          rsp.q_value   = q_table[s][a];
        end
      end
    end
    return rsp;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic qle_pkg::in_req_t make_req(qle_pkg::mode_t m, int s, int a,
                                                logic [Q_W-1:0] r, int ns);
    qle_pkg::in_req_t req;
    req.mode             = m;
    req.state_index      = STATE_W'(s);
    req.action_index     = ACTION_W'(a);
    req.reward           = r;
    req.next_state_index = STATE_W'(ns);
    return req;
  endfunction

  // Mostly a few hot rows so updates build on each other
  function automatic int pick_state();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(7);
    if (sel < 80) return $urandom_range(ROWS - 1, ROWS - 8);
    return $urandom_range(ROWS - 1);
  endfunction

  function automatic logic [Q_W-1:0] pick_reward();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return Q_W'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
      5:             return $urandom_range(1) ? Q_MAX : Q_MIN;
      default:       return $urandom;
    endcase
  endfunction

  function automatic qle_pkg::in_req_t rand_request();
    int             sel;
    qle_pkg::mode_t m;
    sel = $urandom_range(99);
    if (sel < 35)      m = qle_pkg::MODE_UPDATE;
    else if (sel < 55) m = qle_pkg::MODE_TERMINAL;
    else if (sel < 80) m = qle_pkg::MODE_GREEDY;
    else               m = qle_pkg::MODE_READ;
    return make_req(m, pick_state(), $urandom_range(COLS - 1), pick_reward(), pick_state());
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [Q_W-1:0] want, logic [Q_W-1:0] got);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch %0d: %s expected %h got %h", error_count, what, want, got);
  endtask

  // Offer one request; valid stays high afterwards unless a gap follows
  task automatic send_request(qle_pkg::in_req_t req);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_step(req));
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      gap = pick_gap();
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every result is back
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(qle_pkg::cfg_reg_t sel, logic [COEF_W-1:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {sel, 2'b00};
    cfg_pwdata  = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (sel == qle_pkg::CFG_ALPHA) alpha_coef = value;
    else                           gamma_coef = value;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic check_register(qle_pkg::cfg_reg_t sel);
    logic [COEF_W-1:0] want;
    want = (sel == qle_pkg::CFG_ALPHA) ? alpha_coef : gamma_coef;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = {sel, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[COEF_W-1:0] !== want)
      report_mismatch("register readback", Q_W'(want), Q_W'(cfg_prdata[COEF_W-1:0]));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic apply_coefficients(logic [COEF_W-1:0] a, logic [COEF_W-1:0] g);
    wait_results_drained();
    write_register(qle_pkg::CFG_ALPHA, a);
    write_register(qle_pkg::CFG_GAMMA, g);
    check_register(qle_pkg::CFG_ALPHA);
    check_register(qle_pkg::CFG_GAMMA);
  endtask

  // ---------------------------------------------------------------- tests
  // Reset coefficients: zero table, ties, floor rounding, field extremes
  task automatic test_directed_cases();
    send_request(make_req(qle_pkg::MODE_READ,     0,      0, 0,             0));
    send_request(make_req(qle_pkg::MODE_GREEDY,   0,      0, 0,             0));
    send_request(make_req(qle_pkg::MODE_GREEDY,   511,    3, Q_MAX,         511));
    send_request(make_req(qle_pkg::MODE_TERMINAL, 0,      1, Q_MAX,         0));
    send_request(make_req(qle_pkg::MODE_TERMINAL, 0,      2, Q_MIN,         0));
    send_request(make_req(qle_pkg::MODE_GREEDY,   0,      0, 0,             0));
    // equal entries in columns 1 and 3: lowest index must win
    send_request(make_req(qle_pkg::MODE_TERMINAL, 0,      3, Q_MAX,         0));
    send_request(make_req(qle_pkg::MODE_GREEDY,   0,      2, 0,             0));
    send_request(make_req(qle_pkg::MODE_UPDATE,   511,    3, 32'hFFFF_FFFF, 0));
    send_request(make_req(qle_pkg::MODE_UPDATE,   1,      0, 0,             511));
    send_request(make_req(qle_pkg::MODE_READ,     511,    3, 0,             0));
    send_request(make_req(qle_pkg::MODE_READ,     0,      2, 0,             0));
    send_request(make_req(qle_pkg::MODE_UPDATE,   0,      2, Q_MIN,         0));
    send_request(make_req(qle_pkg::MODE_GREEDY,   1,      0, 0,             0));
    // next state equal to own state
    send_request(make_req(qle_pkg::MODE_UPDATE,   2,      1, 32'h0001_0000, 2));
    send_request(make_req(qle_pkg::MODE_UPDATE,   2,      1, 32'h0001_0000, 2));
    send_request(make_req(qle_pkg::MODE_READ,     2,      1, 0,             0));
    // a tiny negative step must floor to minus one lsb
    send_request(make_req(qle_pkg::MODE_TERMINAL, 3,      0, 32'hFFFF_FFFF, 0));
    send_request(make_req(qle_pkg::MODE_READ,     3,      0, 0,             0));
    send_request(make_req(qle_pkg::MODE_GREEDY,   3,      0, 0,             0));
    send_request(make_req(qle_pkg::MODE_UPDATE,   3,      2, 32'h5555_AAAA, 9'h155));
    send_request(make_req(qle_pkg::MODE_UPDATE,   9'h0AA, 1, 32'hAAAA_5555, 9'h0AA));
    send_request(make_req(qle_pkg::MODE_READ,     9'h0AA, 1, 32'h5555_AAAA, 9'h155));
    send_request(make_req(qle_pkg::MODE_GREEDY,   9'h155, 0, 32'hAAAA_5555, 9'h0AA));
  endtask

  // Alpha and gamma at their extremes, driving the sums into saturation
  task automatic test_coefficient_extremes();
    for (int k = 0; k < 4; k++) begin
      apply_coefficients((k % 2 == 0) ? 16'hFFFF : 16'h0000,
                         (k / 2 == 0) ? 16'h0000 : 16'hFFFF);
      send_request(make_req(qle_pkg::MODE_TERMINAL, 8, 0, Q_MIN, 0));
      send_request(make_req(qle_pkg::MODE_TERMINAL, 8, 1, Q_MAX, 0));
      send_request(make_req(qle_pkg::MODE_UPDATE,   8, 0, Q_MAX, 8));
      send_request(make_req(qle_pkg::MODE_UPDATE,   8, 1, Q_MIN, 8));
      send_request(make_req(qle_pkg::MODE_UPDATE,   9, 3, Q_MAX, 8));
      send_request(make_req(qle_pkg::MODE_UPDATE,   8, 2, Q_MIN, 9));
      send_request(make_req(qle_pkg::MODE_GREEDY,   8, 0, 0,     0));
      send_request(make_req(qle_pkg::MODE_READ,     8, 0, 0,     0));
    end
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_result_backpressure();
    in_idle_pct  = 0;
    hold_results = 1'b1;
    repeat (24) send_request(rand_request());
    wait_results_drained();
    in_idle_pct = 25;
  endtask

  // Random traffic over several coefficient settings
  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       apply_coefficients(qle_pkg::ALPHA_RST, qle_pkg::GAMMA_RST);
        1:       apply_coefficients(COEF_W'($urandom), COEF_W'($urandom));
        2:       apply_coefficients(16'hFFFF, COEF_W'($urandom));
        3:       apply_coefficients(COEF_W'($urandom_range(16'h00FF)), 16'hFFFF);
        4:       apply_coefficients(COEF_W'($urandom), 16'h0000);
        default: apply_coefficients(16'h0001, 16'h0001);
      endcase
      // one phase runs with no idling on either side
      if (p == 2) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = $urandom_range(10, 40);
        out_idle_pct = $urandom_range(5, 25);
      end
      repeat (115) send_request(rand_request());
    end
  endtask

  // ---------------------------------------------------------------- result side
  // Receiver ready with random gaps and one commanded long hold-off
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready = 1'b0;
        repeat (RESULT_HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
        out_ready    = 1'b1;
      end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
        gap = pick_gap();
        out_ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin : check_results
    qle_pkg::out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no pending request", '0, out_data.q_value);
      end else begin
        want = pending_results.pop_front();
        if (out_data.best_action !== want.best_action) begin
          report_mismatch("best_action", Q_W'(want.best_action), Q_W'(out_data.best_action));
        end
        if (out_data.q_value !== want.q_value) begin
          report_mismatch("q_value", want.q_value, out_data.q_value);
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    alpha_coef  = qle_pkg::ALPHA_RST;
    gamma_coef  = qle_pkg::GAMMA_RST;
    foreach (q_table[r, c]) q_table[r][c] = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_coefficient_extremes();
    test_result_backpressure();
    test_random_traffic();
    wait_results_drained();

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
